// ----- rtl/core/first_fit_heap_allocator_defines.svh -----
// Assertion macros for the first-fit heap allocator.
// Included by the top level; no other dependencies.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/ffha_pkg.sv -----
// Shared types and constants for the first-fit heap allocator.
// No dependencies.
package ffha_pkg;

    localparam int unsigned HEAP_BYTES   = 16384;
    localparam int unsigned HEADER_BYTES = 20;
    localparam int unsigned MAX_BLOCKS   = 1024;

    localparam int unsigned OFF_W  = 14;
    localparam int unsigned PAY_W  = 15;
    localparam int unsigned NEED_W = PAY_W + 1;
    localparam int unsigned IDX_W  = $clog2(MAX_BLOCKS);
    localparam int unsigned CNT_W  = IDX_W + 1;
    localparam int unsigned LIVE_W = 11;
    localparam int unsigned EVT_W  = 32;

    localparam int unsigned HDR_ALIGNED  = (HEADER_BYTES + 7) / 8 * 8;
    localparam int unsigned MIN_BLOCK    = HDR_ALIGNED + 8;
    localparam int unsigned HEAP_ALIGNED = HEAP_BYTES / 8 * 8;
    localparam int unsigned INIT_PAY     = HEAP_ALIGNED - HEADER_BYTES;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_ZERO    = 2'd1,
        STAT_NOFIT   = 2'd2,
        STAT_BADFREE = 2'd3
    } status_t;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    // One heap table entry
    typedef struct packed {
        logic [OFF_W-1:0] off;
        logic [PAY_W-1:0] pay;
        logic             is_free;
    } blk_t;

    // Counter update requests from the sequencer
    typedef struct packed {
        logic             alloc;
        logic             release_blk;
        logic             split;
        logic             nofit;
        logic             badfree;
        logic [PAY_W-1:0] pay;
    } stats_cmd_t;

    // Counter values
    typedef struct packed {
        logic [PAY_W-1:0]  free_bytes;
        logic [PAY_W-1:0]  used_bytes;
        logic [PAY_W-1:0]  peak_bytes;
        logic [LIVE_W-1:0] live;
        logic [EVT_W-1:0]  nofit;
        logic [EVT_W-1:0]  badfree;
    } stats_t;

endpackage

// ----- rtl/core/ffha_stats.sv -----
// Running statistics counters of the heap allocator.
// Depends on ffha_pkg.
module ffha_stats (
    input  logic                aclk,
    input  logic                aresetn,
    input  ffha_pkg::stats_cmd_t cmd,
    output ffha_pkg::stats_t     stats
);
    import ffha_pkg::*;

    stats_t stats_reg, stats_next;
    logic [PAY_W-1:0] used_sum;

    // Apply at most one update per cycle
    always_comb begin
        stats_next = stats_reg;
        used_sum   = stats_reg.used_bytes + cmd.pay;
        if (cmd.alloc) begin
            stats_next.used_bytes = used_sum;
            stats_next.free_bytes = stats_reg.free_bytes - cmd.pay
                                    - (cmd.split ? PAY_W'(HEADER_BYTES) : '0);
            stats_next.live       = stats_reg.live + 1'b1;
            if (used_sum > stats_reg.peak_bytes) begin
                stats_next.peak_bytes = used_sum;
            end
        end else if (cmd.release_blk) begin
            stats_next.used_bytes = stats_reg.used_bytes - cmd.pay;
            stats_next.free_bytes = stats_reg.free_bytes + cmd.pay;
            if (stats_reg.live != '0) begin
                stats_next.live = stats_reg.live - 1'b1;
            end
        end else if (cmd.nofit) begin
            stats_next.nofit = stats_reg.nofit + 1'b1;
        end else if (cmd.badfree) begin
            stats_next.badfree = stats_reg.badfree + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stats_reg.free_bytes <= PAY_W'(INIT_PAY);
            stats_reg.used_bytes <= '0;
            stats_reg.peak_bytes <= '0;
            stats_reg.live       <= '0;
            stats_reg.nofit      <= '0;
            stats_reg.badfree    <= '0;
        end else begin
            stats_reg <= stats_next;
        end
    end

    assign stats = stats_reg;

endmodule

// ----- rtl/core/first_fit_heap_allocator.sv -----
// First-fit heap allocator with coalescing: table sequencer and result port.
// Depends on ffha_pkg, ffha_stats and first_fit_heap_allocator_defines.svh.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | req_type, req_size, req_addr
//  m_      | out       | m_valid / m_ready  | status, alloc_addr, counters
//
// One item at a time. A scan reads one table entry a cycle through the memory's
// single read port; a split shifts the entries above the hit up one a cycle and a
// merge shifts them down one a cycle. After reset the initial free block is
// written before s_ready rises.
// A result waiting on m_ready does not stop the next item from being taken.
`include "first_fit_heap_allocator_defines.svh"

module first_fit_heap_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [14:0]                   s_req_size,
    input  logic [ffha_pkg::OFF_W-1:0]    s_req_addr,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [ffha_pkg::OFF_W-1:0]    m_alloc_addr,
    output logic [ffha_pkg::PAY_W-1:0]    m_free_bytes,
    output logic [ffha_pkg::PAY_W-1:0]    m_used_bytes,
    output logic [ffha_pkg::PAY_W-1:0]    m_peak_used_bytes,
    output logic [ffha_pkg::LIVE_W-1:0]   m_outstanding_count,
    output logic [ffha_pkg::EVT_W-1:0]    m_fail_count,
    output logic [ffha_pkg::EVT_W-1:0]    m_bad_free_count
);
    import ffha_pkg::*;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_SCAN, ST_A_HIT, ST_MOVE, ST_A_WR1, ST_A_WR0,
        ST_F_RDN, ST_F_MRG, ST_F_WR, ST_DONE
    } state_t;

    localparam logic [PAY_W-1:0] HDR = PAY_W'(HEADER_BYTES);

    // Block table memory
    blk_t             mem [MAX_BLOCKS];
    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    blk_t             wr_data, rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Sequencer registers
    state_t            state_reg, state_next;
    req_t              type_reg, type_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [OFF_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  pidx_reg, pidx_next;
    logic [CNT_W-1:0]  hit_reg, hit_next;
    blk_t              cur_reg, cur_next;
    blk_t              prev_reg, prev_next;
    logic              nf_reg, nf_next;
    logic              pf_reg, pf_next;
    logic [PAY_W-1:0]  sum_reg, sum_next;
    logic              up_reg, up_next;
    logic [1:0]        k_reg, k_next;
    status_t           status_reg, status_next;
    logic [OFF_W-1:0]  aaddr_reg, aaddr_next;
    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    logic [OFF_W-1:0]  m_aaddr_reg, m_aaddr_next;
    stats_t            m_stats_reg, m_stats_next;

    stats_cmd_t        cmd;
    stats_t            stats;

    logic              match, issue;
    logic [PAY_W-1:0]  rest;
    logic              split;
    logic [CNT_W-1:0]  hit_p1;

    ffha_stats u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stats   (stats)
    );

    assign hit_p1 = hit_reg + 1'b1;
    assign rest   = cur_reg.pay - need_reg[PAY_W-1:0];
    assign split  = (rest >= PAY_W'(MIN_BLOCK)) && (cnt_reg < CNT_W'(MAX_BLOCKS));

    // Scan compare against the entry that arrived this cycle
    always_comb begin
        if (type_reg == REQ_ALLOC) begin
            match = rdata_reg.is_free && ({1'b0, rdata_reg.pay} >= need_reg);
        end else begin
            match = (PAY_W'(rdata_reg.off) + HDR) == PAY_W'(addr_reg);
        end
    end

    // Next-state logic
    always_comb begin
        state_next    = state_reg;
        type_next     = type_reg;
        need_next     = need_reg;
        addr_next     = addr_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        pidx_next     = pidx_reg;
        hit_next      = hit_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        nf_next       = nf_reg;
        pf_next       = pf_reg;
        sum_next      = sum_reg;
        up_next       = up_reg;
        k_next        = k_reg;
        status_next   = status_reg;
        aaddr_next    = aaddr_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_aaddr_next  = m_aaddr_reg;
        m_stats_next  = m_stats_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = hit_reg[IDX_W-1:0];
        wr_data       = rdata_reg;
        issue         = 1'b0;
        s_ready       = 1'b0;
        cmd           = '0;

        case (state_reg)
            ST_INIT: begin
                // Initial single free block
                wr_en        = 1'b1;
                wr_addr      = '0;
                wr_data.off  = '0;
                wr_data.pay  = PAY_W'(INIT_PAY);
                wr_data.is_free = 1'b1;
                cnt_next     = CNT_W'(1);
                state_next   = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    type_next  = req_t'(s_req_type);
                    need_next  = (NEED_W'(s_req_size) + NEED_W'(7)) & ~NEED_W'(7);
                    addr_next  = s_req_addr;
                    idx_next   = '0;
                    aaddr_next = '0;
                    if (s_req_type == REQ_ALLOC && s_req_size == '0) begin
                        status_next = STAT_ZERO;
                        state_next  = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Issue the next read while checking the previous one
                issue = idx_reg < cnt_reg;
                rd_en = issue;
                if (issue) begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                end
                if (pend_reg) begin
                    if (match) begin
                        pend_next = 1'b0;
                        cur_next  = rdata_reg;
                        hit_next  = pidx_reg;
                        if (type_reg == REQ_ALLOC) begin
                            state_next = ST_A_HIT;
                        end else if (rdata_reg.is_free) begin
                            cmd.badfree = 1'b1;
                            status_next = STAT_BADFREE;
                            state_next  = ST_DONE;
                        end else begin
                            state_next = ST_F_RDN;
                        end
                    end else begin
                        prev_next = rdata_reg;
                        if (pidx_reg == cnt_reg - 1'b1) begin
                            pend_next = 1'b0;
                            if (type_reg == REQ_ALLOC) begin
                                cmd.nofit   = 1'b1;
                                status_next = STAT_NOFIT;
                            end else begin
                                cmd.badfree = 1'b1;
                                status_next = STAT_BADFREE;
                            end
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_A_HIT: begin
                status_next = STAT_OK;
                aaddr_next  = cur_reg.off + OFF_W'(HEADER_BYTES);
                cmd.alloc   = 1'b1;
                if (!split) begin
                    cmd.pay         = cur_reg.pay;
                    wr_en           = 1'b1;
                    wr_data         = cur_reg;
                    wr_data.is_free = 1'b0;
                    state_next      = ST_DONE;
                end else begin
                    cmd.pay   = need_reg[PAY_W-1:0];
                    cmd.split = 1'b1;
                    sum_next  = rest;
                    if (hit_p1 < cnt_reg) begin
                        idx_next   = cnt_reg - 1'b1;
                        up_next    = 1'b1;
                        state_next = ST_MOVE;
                    end else begin
                        state_next = ST_A_WR1;
                    end
                end
            end
            ST_MOVE: begin
                // Copy one entry per cycle, read and write overlapped
                if (up_reg) begin
                    issue = idx_reg > hit_reg;
                end else begin
                    issue = idx_reg < cnt_reg;
                end
                rd_en = issue;
                if (issue) begin
                    idx_next  = up_reg ? idx_reg - 1'b1 : idx_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = idx_reg;
                end
                if (pend_reg) begin
                    wr_en = 1'b1;
                    if (up_reg) begin
                        wr_addr = IDX_W'(pidx_reg + 1'b1);
                    end else begin
                        wr_addr = IDX_W'(pidx_reg - CNT_W'(k_reg));
                    end
                end
                if (!issue && !pend_reg) begin
                    if (up_reg) begin
                        state_next = ST_A_WR1;
                    end else begin
                        cnt_next   = cnt_reg - CNT_W'(k_reg);
                        state_next = ST_DONE;
                    end
                end
            end
            ST_A_WR1: begin
                // Remainder block above the allocation
                wr_en           = 1'b1;
                wr_addr         = hit_p1[IDX_W-1:0];
                wr_data.off     = OFF_W'(NEED_W'(cur_reg.off) + NEED_W'(HEADER_BYTES)
                                  + need_reg);
                wr_data.pay     = sum_reg - HDR;
                wr_data.is_free = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                state_next      = ST_A_WR0;
            end
            ST_A_WR0: begin
                wr_en           = 1'b1;
                wr_data.off     = cur_reg.off;
                wr_data.pay     = need_reg[PAY_W-1:0];
                wr_data.is_free = 1'b0;
                state_next      = ST_DONE;
            end
            ST_F_RDN: begin
                // Fetch the next neighbor and release the payload
                rd_en           = hit_p1 < cnt_reg;
                rd_addr         = hit_p1[IDX_W-1:0];
                cmd.release_blk = 1'b1;
                cmd.pay         = cur_reg.pay;
                status_next     = STAT_OK;
                state_next      = ST_F_MRG;
            end
            ST_F_MRG: begin
                nf_next    = (hit_p1 < cnt_reg) && rdata_reg.is_free;
                pf_next    = (hit_reg != '0) && prev_reg.is_free;
                sum_next   = cur_reg.pay;
                if ((hit_p1 < cnt_reg) && rdata_reg.is_free) begin
                    sum_next = cur_reg.pay + rdata_reg.pay + HDR;
                end
                state_next = ST_F_WR;
            end
            ST_F_WR: begin
                wr_en           = 1'b1;
                wr_data.is_free = 1'b1;
                if (pf_reg) begin
                    wr_addr     = IDX_W'(hit_reg - 1'b1);
                    wr_data.off = prev_reg.off;
                    wr_data.pay = prev_reg.pay + sum_reg + HDR;
                end else begin
                    wr_data.off = cur_reg.off;
                    wr_data.pay = sum_reg;
                end
                k_next = {1'b0, nf_reg} + {1'b0, pf_reg};
                if (nf_reg || pf_reg) begin
                    idx_next   = hit_p1 + CNT_W'(nf_reg);
                    up_next    = 1'b0;
                    state_next = ST_MOVE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_aaddr_next  = (status_reg == STAT_OK) ? aaddr_reg : '0;
                    m_stats_next  = stats;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            pend_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        type_reg     <= type_next;
        need_reg     <= need_next;
        addr_reg     <= addr_next;
        idx_reg      <= idx_next;
        pidx_reg     <= pidx_next;
        hit_reg      <= hit_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        nf_reg       <= nf_next;
        pf_reg       <= pf_next;
        sum_reg      <= sum_next;
        up_reg       <= up_next;
        k_reg        <= k_next;
        status_reg   <= status_next;
        aaddr_reg    <= aaddr_next;
        m_status_reg <= m_status_next;
        m_aaddr_reg  <= m_aaddr_next;
        m_stats_reg  <= m_stats_next;
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = m_status_reg;
    assign m_alloc_addr        = m_aaddr_reg;
    assign m_free_bytes        = m_stats_reg.free_bytes;
    assign m_used_bytes        = m_stats_reg.used_bytes;
    assign m_peak_used_bytes   = m_stats_reg.peak_bytes;
    assign m_outstanding_count = m_stats_reg.live;
    assign m_fail_count        = m_stats_reg.nofit;
    assign m_bad_free_count    = m_stats_reg.badfree;

    // Checks
    `FFHA_ASSERT_IMPL(a_cnt_range, aclk, aresetn, state_reg == ST_IDLE,
        cnt_reg != '0 && cnt_reg <= CNT_W'(MAX_BLOCKS), "block count out of range")
    `FFHA_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready,
        !s_ready, "item taken while busy")
    `FFHA_ASSERT_IMPL(a_addr_zero, aclk, aresetn, m_valid && m_status != STAT_OK,
        m_alloc_addr == '0, "address set on failed item")

endmodule
